>>> design/fptm_pkg.sv
// shared constants, entry bit layout and codes for the four-level page table mapper
package fptm_pkg;

    localparam int TABLE_FRAMES_DEF = 64;

    localparam int ENTRY_W   = 64;
    localparam int FRAME_W   = 40;
    localparam int VA_W      = 48;
    localparam int PA_W      = 52;
    localparam int FLAGS_W   = 12;
    localparam int IDX_W     = 9;
    localparam int STATUS_W  = 2;
    localparam int TABLES_W  = 7;
    localparam int PAGE_SHIFT = 12;

    // index slice positions, top level first
    localparam int SHIFT_L4 = 39;
    localparam int SHIFT_L3 = 30;
    localparam int SHIFT_L2 = 21;
    localparam int SHIFT_L1 = 12;

    localparam logic [FRAME_W-1:0] POOL_BASE_RESET = FRAME_W'(256);

    localparam logic [ENTRY_W-1:0] PTE_PRESENT = ENTRY_W'(64'h1);
    localparam logic [ENTRY_W-1:0] PTE_WRITE   = ENTRY_W'(64'h2);
    localparam logic [ENTRY_W-1:0] PTE_USER    = ENTRY_W'(64'h4);
    localparam logic [ENTRY_W-1:0] ADDR_KEEP   = ~ENTRY_W'(64'hFFF);

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 2'd2;

endpackage

>>> design/fptm_table_ram.sv
// table frame store: one write port, one read port with registered read data
module fptm_table_ram #(
    parameter int DEPTH  = fptm_pkg::TABLE_FRAMES_DEF * 512,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int WIDTH  = fptm_pkg::ENTRY_W + 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/four_level_page_table_mapper.sv
// four-level page table mapper: walk engine, pool counter and result register
//
// Input channel s_axis: one item is a map (tuser 0) or unmap (tuser 1) request;
// tdata carries virt_addr, phys_addr and page_flags. Output channel m_axis gives
// one result item per request: tuser holds the status, tdata the leaf entry
// written and the number of table frames in use.
// cfg_wr_en / cfg_wr_data load pool_base_frame; write it only while no request
// is in flight.
// After reset the block runs a clearing pass over all TABLE_FRAMES * 512 entries
// of the table store, one entry per cycle, with s_axis_tready low. The root
// table is frame slot 0 and the pool counter starts at one.
// Each request walks the three upper levels through ST_READ (memory read) and
// ST_EVAL (check and optional pointer write); ST_LEAF then writes the leaf entry
// and ST_DONE loads the result register. A walk that misses at an upper level
// goes straight to ST_DONE. A new item is accepted only after the previous one
// has loaded the result register, so requests do not overlap; the dependent
// reads through the table store keep the walk serial.
// A result waits in the output register while m_axis_tready is low; the next
// item is still accepted and walked, and holds at its end until the register
// frees up.
module four_level_page_table_mapper #(
    parameter int TABLE_FRAMES = fptm_pkg::TABLE_FRAMES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,

    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,   // virt_addr[47:0], phys_addr[99:48], page_flags[111:100]
    input  logic          s_axis_tuser,   // operation

    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata,   // leaf_entry[63:0], tables_in_use[70:64], zero pad[71]
    output logic [1:0]    m_axis_tuser,   // status

    input  logic          cfg_wr_en,
    input  logic [39:0]   cfg_wr_data     // pool_base_frame
);

    localparam int SLOT_W = $clog2(TABLE_FRAMES);
    localparam int ADDR_W = SLOT_W + fptm_pkg::IDX_W;
    localparam int DEPTH  = TABLE_FRAMES * 512;
    localparam int CNT_W  = $clog2(TABLE_FRAMES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_LEAF,
        ST_DONE
    } state_t;

    state_t                           state_reg;
    logic [ADDR_W-1:0]                clear_cnt_reg;
    logic [fptm_pkg::FRAME_W-1:0]     pool_base_reg;
    logic [CNT_W-1:0]                 frames_used_reg;

    logic                             op_reg;
    logic [fptm_pkg::VA_W-1:0]        va_reg;
    logic [fptm_pkg::PA_W-1:0]        pa_reg;
    logic [fptm_pkg::FLAGS_W-1:0]     flags_reg;
    logic [1:0]                       level_reg;
    logic [SLOT_W-1:0]                slot_reg;
    logic [fptm_pkg::STATUS_W-1:0]    status_reg;
    logic [fptm_pkg::ENTRY_W-1:0]     leaf_reg;

    logic                             m_valid_reg;
    logic [fptm_pkg::STATUS_W-1:0]    m_status_reg;
    logic [fptm_pkg::ENTRY_W-1:0]     m_leaf_reg;
    logic [fptm_pkg::TABLES_W-1:0]    m_tables_reg;

    logic [fptm_pkg::IDX_W-1:0]       idx;
    logic [ADDR_W-1:0]                entry_addr;
    logic                             mem_wr_en;
    logic [ADDR_W-1:0]                mem_wr_addr;
    logic [fptm_pkg::ENTRY_W-1:0]     mem_wr_data;
    logic                             mem_wr_tag;
    logic                             mem_rd_en;
    logic [fptm_pkg::ENTRY_W:0]       mem_rd_word;
    logic [fptm_pkg::ENTRY_W-1:0]     mem_rd_data;
    logic                             slot_live;

    logic [fptm_pkg::FRAME_W-1:0]     rel_frame;
    logic                             hit;
    logic                             pool_full;
    logic [fptm_pkg::FRAME_W-1:0]     alloc_frame;
    logic [fptm_pkg::ENTRY_W-1:0]     ptr_entry;
    logic [fptm_pkg::ENTRY_W-1:0]     leaf_entry;
    logic [CNT_W+fptm_pkg::TABLES_W-1:0] frames_ext;
    logic                             accept;
    logic                             out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    // index slice for the current level; level 3 means the leaf table
    always_comb
    begin
        case (level_reg)
            2'd0:    idx = va_reg[fptm_pkg::SHIFT_L4 +: fptm_pkg::IDX_W];
            2'd1:    idx = va_reg[fptm_pkg::SHIFT_L3 +: fptm_pkg::IDX_W];
            2'd2:    idx = va_reg[fptm_pkg::SHIFT_L2 +: fptm_pkg::IDX_W];
            default: idx = va_reg[fptm_pkg::SHIFT_L1 +: fptm_pkg::IDX_W];
        endcase
    end

    assign entry_addr = {slot_reg, idx};

    // slots are handed out in order, so a slot below the counter is allocated
    assign slot_live = CNT_W'(slot_reg) < frames_used_reg;

    // the top bit marks an entry written after its table was allocated; an unmarked
    // entry of an allocated table reads as zero, which clears a table as it is taken
    assign mem_rd_data = (slot_live && !mem_rd_word[fptm_pkg::ENTRY_W]) ? '0
                       : mem_rd_word[fptm_pkg::ENTRY_W-1:0];

    // a present entry counts only if its frame falls inside the pool
    assign rel_frame = mem_rd_data[fptm_pkg::PAGE_SHIFT +: fptm_pkg::FRAME_W] - pool_base_reg;
    assign hit       = mem_rd_data[0] && (rel_frame < fptm_pkg::FRAME_W'(TABLE_FRAMES));
    assign pool_full = frames_used_reg >= CNT_W'(TABLE_FRAMES);

    assign alloc_frame = pool_base_reg + fptm_pkg::FRAME_W'(frames_used_reg);
    assign ptr_entry   = (fptm_pkg::ENTRY_W'(alloc_frame) << fptm_pkg::PAGE_SHIFT)
                       | fptm_pkg::PTE_PRESENT | fptm_pkg::PTE_WRITE
                       | (fptm_pkg::ENTRY_W'(flags_reg) & fptm_pkg::PTE_USER);
    assign leaf_entry  = (fptm_pkg::ENTRY_W'(pa_reg) & fptm_pkg::ADDR_KEEP)
                       | fptm_pkg::PTE_PRESENT | fptm_pkg::ENTRY_W'(flags_reg);

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = entry_addr;
        mem_wr_data = ptr_entry;
        mem_wr_tag  = slot_live;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clear_cnt_reg;
                mem_wr_data = '0;
                mem_wr_tag  = 1'b0;
            end
            ST_EVAL:
            begin
                mem_wr_en = !hit && (op_reg == fptm_pkg::OP_MAP) && !pool_full;
            end
            ST_LEAF:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = (op_reg == fptm_pkg::OP_MAP) ? leaf_entry : '0;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    assign mem_rd_en = (state_reg == ST_READ);

    fptm_table_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (fptm_pkg::ENTRY_W + 1)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data ({mem_wr_tag, mem_wr_data}),
        .rd_en   (mem_rd_en),
        .rd_addr (entry_addr),
        .rd_data (mem_rd_word)
    );

    assign frames_ext = {{fptm_pkg::TABLES_W{1'b0}}, frames_used_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clear_cnt_reg   <= '0;
            pool_base_reg   <= fptm_pkg::POOL_BASE_RESET;
            frames_used_reg <= CNT_W'(1);
            op_reg          <= fptm_pkg::OP_MAP;
            va_reg          <= '0;
            pa_reg          <= '0;
            flags_reg       <= '0;
            level_reg       <= '0;
            slot_reg        <= '0;
            status_reg      <= fptm_pkg::STATUS_DONE;
            leaf_reg        <= '0;
            m_valid_reg     <= 1'b0;
            m_status_reg    <= fptm_pkg::STATUS_DONE;
            m_leaf_reg      <= '0;
            m_tables_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pool_base_reg <= cfg_wr_data;
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
                    if (clear_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= s_axis_tuser;
                        va_reg     <= s_axis_tdata[47:0];
                        pa_reg     <= s_axis_tdata[99:48];
                        flags_reg  <= s_axis_tdata[111:100];
                        level_reg  <= '0;
                        slot_reg   <= '0;
                        status_reg <= fptm_pkg::STATUS_DONE;
                        leaf_reg   <= '0;
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (hit || (op_reg == fptm_pkg::OP_MAP && !pool_full))
                    begin
                        if (hit)
                        begin
                            slot_reg <= rel_frame[SLOT_W-1:0];
                        end
                        else
                        begin
                            // fresh table, its unmarked entries read as zero
                            slot_reg        <= frames_used_reg[SLOT_W-1:0];
                            frames_used_reg <= frames_used_reg + CNT_W'(1);
                        end
                        level_reg <= level_reg + 2'd1;
                        state_reg <= (level_reg == 2'd2) ? ST_LEAF : ST_READ;
                    end
                    else
                    begin
                        status_reg <= (op_reg == fptm_pkg::OP_UNMAP) ? fptm_pkg::STATUS_ABSENT
                                                                     : fptm_pkg::STATUS_NO_FRAME;
                        state_reg  <= ST_DONE;
                    end
                end
                ST_LEAF:
                begin
                    leaf_reg  <= (op_reg == fptm_pkg::OP_MAP) ? leaf_entry : '0;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_status_reg <= status_reg;
                        m_leaf_reg   <= leaf_reg;
                        m_tables_reg <= frames_ext[fptm_pkg::TABLES_W-1:0];
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {1'b0, m_tables_reg, m_leaf_reg};

    // pool counter never passes the number of table frames
    assert property (@(posedge clk) disable iff (!rst_n)
        frames_used_reg <= CNT_W'(TABLE_FRAMES))
        else $error("frame pool counter overflow");

    // the pool counter only steps up by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (frames_used_reg != $past(frames_used_reg)) |->
        (frames_used_reg == $past(frames_used_reg) + CNT_W'(1)))
        else $error("frame pool counter jumped");

    // a new result item only comes out of the final walk state
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !$past(m_valid_reg && !m_axis_tready) && $past(rst_n)) |->
        $past(state_reg == ST_DONE))
        else $error("result loaded outside the final walk state");

    // an error result never carries a leaf entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != fptm_pkg::STATUS_DONE) |-> (m_leaf_reg == '0))
        else $error("error result with nonzero leaf");

    // no request is taken before the clearing pass is over
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !$past(accept))
        else $error("request accepted during clearing pass");

endmodule
